FILE: rtl/core/ragged_index_converter_macros.svh
// Assertion macros for the ragged index converter checker.
// Each expects clk and rst_n in the scope of use.
`ifndef RAGGED_INDEX_CONVERTER_MACROS_SVH
`define RAGGED_INDEX_CONVERTER_MACROS_SVH

// same-cycle implication
`define RIC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ric_pkg.sv
// Shared types and codes for the ragged index converter.
// No dependencies.
package ric_pkg;

    localparam int DEF_MAX_RANK     = 8;
    localparam int DEF_OFFSET_DEPTH = 4096;
    localparam int DEF_INDEX_BITS   = 32;
    localparam int CMDQ_DEPTH       = 4;
    localparam int RESQ_DEPTH       = 2;

    localparam logic [1:0] OP_LOAD_DIM = 2'd0;
    localparam logic [1:0] OP_LOAD_OFF = 2'd1;
    localparam logic [1:0] OP_TO_FLAT  = 2'd2;
    localparam logic [1:0] OP_TO_MULTI = 2'd3;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_COUNT    = 2'd1;
    localparam logic [1:0] ERR_RANGE    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    localparam logic KIND_FLAT  = 1'b0;
    localparam logic KIND_MULTI = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  dsel;
        logic        jagged;
        logic [15:0] size;
        logic [11:0] tidx;
        logic        ok;
        logic [31:0] value;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] flat;
        logic [2:0]  dim;
        logic [31:0] comp;
        logic [31:0] row;
        logic        last;
        logic [1:0]  err;
    } res_t;

endpackage

FILE: rtl/core/ric_fifo.sv
// Small synchronous queue for requests and results.
// No package dependency.
module ric_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = PW + 1;

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next;
    logic [PW-1:0]    rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = data_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wp_next  = do_wr ? ((wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next  = do_rd ? ((rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + CW'(do_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wp_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/ric_front.sv
// Front end: takes input requests, range-checks loads and packs a command.
// Depends on ric_pkg and ric_fifo.
module ric_front #(
    parameter int MAX_RANK     = 8,
    parameter int OFFSET_DEPTH = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     action,
    input  logic [2:0]     dim_select,
    input  logic           dim_jagged,
    input  logic [15:0]    dim_size,
    input  logic [11:0]    table_index,
    input  logic [31:0]    prefix_value,
    input  logic [31:0]    index_component,
    input  logic           last_component,
    input  logic [31:0]    flat_in,
    output ric_pkg::cmd_t  cmd,
    output logic           cmd_valid,
    input  logic           cmd_pop
);
    import ric_pkg::*;

    cmd_t cmd_in;
    logic q_empty;
    logic dim_ok;

    assign dim_ok = (32'(dim_select) < 32'(MAX_RANK));

    always_comb
    begin
        cmd_in.op     = action;
        cmd_in.dsel   = dim_select;
        cmd_in.jagged = dim_jagged;
        cmd_in.size   = dim_size;
        cmd_in.tidx   = table_index;
        cmd_in.last   = last_component;
        case (action)
            OP_LOAD_DIM:
            begin
                cmd_in.ok    = dim_ok;
                cmd_in.value = prefix_value;
            end
            OP_LOAD_OFF:
            begin
                cmd_in.ok    = dim_ok && (32'(table_index) < 32'(OFFSET_DEPTH));
                cmd_in.value = prefix_value;
            end
            OP_TO_FLAT:
            begin
                cmd_in.ok    = 1'b1;
                cmd_in.value = index_component;
            end
            default:
            begin
                cmd_in.ok    = 1'b1;
                cmd_in.value = flat_in;
            end
        endcase
    end

    ric_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (cmd_in),
        .rd    (cmd_pop),
        .rdata (cmd),
        .full  (full),
        .empty (q_empty)
    );

    assign cmd_valid = !q_empty;

endmodule

FILE: rtl/core/ric_back.sv
// Back end: shape registers, offset table memory and the conversion sequencer.
// Depends on ric_pkg.
module ric_back #(
    parameter int MAX_RANK     = 8,
    parameter int OFFSET_DEPTH = 4096,
    parameter int INDEX_BITS   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [3:0]     cfg_data,
    input  ric_pkg::cmd_t  cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    output ric_pkg::res_t  res_data,
    output logic           res_push,
    input  logic           res_full
);
    import ric_pkg::*;

    localparam int DW        = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int IW        = $clog2(OFFSET_DEPTH);
    localparam int MEM_WORDS = MAX_RANK * OFFSET_DEPTH;
    localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int VB        = (INDEX_BITS < 32) ? INDEX_BITS : 32;
    localparam logic [31:0] LIM = 32'((64'd1 << VB) - 64'd1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FLAT2 = 4'd1;
    localparam logic [3:0] S_CNT   = 4'd2;
    localparam logic [3:0] S_CNT2  = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_SPLIT = 4'd5;
    localparam logic [3:0] S_BS    = 4'd6;
    localparam logic [3:0] S_BSR   = 4'd7;
    localparam logic [3:0] S_BSE   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_PUSH  = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic        kinds_reg [MAX_RANK];
    logic        kinds_next [MAX_RANK];
    logic [15:0] sizes_reg [MAX_RANK];
    logic [15:0] sizes_next [MAX_RANK];
    logic [3:0]  rank_reg;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  seen_reg, seen_next;
    logic        ovf_seen_reg, ovf_seen_next;

    logic        use_reg, use_next;
    logic [31:0] ccomp_reg, ccomp_next;
    logic        clast_reg, clast_next;
    logic [47:0] prod_reg, prod_next;
    logic [31:0] count_reg, count_next;
    logic [3:0]  cd_reg, cd_next;
    logic        movf_reg, movf_next;
    logic [31:0] flat_reg, flat_next;
    logic [31:0] before_reg [MAX_RANK];
    logic [31:0] before_next [MAX_RANK];
    logic [31:0] comp_reg [MAX_RANK];
    logic [31:0] comp_next [MAX_RANK];
    logic [31:0] row_reg [MAX_RANK];
    logic [31:0] row_next [MAX_RANK];
    logic [31:0] res_reg, res_next;
    logic [DW-1:0] dd_reg, dd_next;
    logic [32:0] lo_reg, lo_next;
    logic [32:0] hi_reg, hi_next;
    logic [32:0] mid_reg, mid_next;
    logic [31:0] q_reg, q_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic [3:0]  eo_reg, eo_next;
    res_t        pend_reg, pend_next;

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rd_data_reg;
    logic        rd_zero_reg;
    logic        rd_en;
    logic [DW-1:0] rd_d;
    logic [32:0] rd_i;
    logic [AW-1:0] rd_addr;
    logic        mem_we;
    logic [AW-1:0] wr_addr;
    logic [31:0] tab;
    logic [3:0]  rank_eff;

    assign rank_eff = (rank_reg > 4'(MAX_RANK)) ? 4'(MAX_RANK) : rank_reg;
    assign tab      = rd_zero_reg ? 32'd0 : rd_data_reg;
    assign rd_addr  = AW'(32'(rd_d) * 32'(OFFSET_DEPTH) + 32'(rd_i[IW-1:0]));
    assign wr_addr  = AW'(32'(cmd.dsel) * 32'(OFFSET_DEPTH) + 32'(cmd.tidx));

    always_comb
    begin
        logic [DW-1:0] d;
        logic [48:0]   v;
        logic [31:0]   acc_n;
        logic [3:0]    seen_n;
        logic          ovf_n;
        logic [1:0]    err;
        logic [32:0]   mid_c;
        logic [16:0]   t;
        logic          ge;
        logic [15:0]   rem_n;
        logic [31:0]   q_n;
        logic          nextd;
        logic          adv;
        logic          olast;

        state_next    = state_reg;
        kinds_next    = kinds_reg;
        sizes_next    = sizes_reg;
        acc_next      = acc_reg;
        seen_next     = seen_reg;
        ovf_seen_next = ovf_seen_reg;
        use_next      = use_reg;
        ccomp_next    = ccomp_reg;
        clast_next    = clast_reg;
        prod_next     = prod_reg;
        count_next    = count_reg;
        cd_next       = cd_reg;
        movf_next     = movf_reg;
        flat_next     = flat_reg;
        before_next   = before_reg;
        comp_next     = comp_reg;
        row_next      = row_reg;
        res_next      = res_reg;
        dd_next       = dd_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        eo_next       = eo_reg;
        pend_next     = pend_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        rd_d          = dd_reg;
        rd_i          = '0;
        res_push      = 1'b0;
        d             = dd_reg;
        v             = '0;
        acc_n         = acc_reg;
        seen_n        = seen_reg;
        ovf_n         = ovf_seen_reg;
        err           = ERR_OK;
        mid_c         = lo_reg + ((hi_reg - lo_reg) >> 1);
        t             = {rem_reg, q_reg[31]};
        ge            = 1'b0;
        rem_n         = rem_reg;
        q_n           = q_reg;
        nextd         = 1'b0;
        adv           = 1'b0;
        olast         = (eo_reg + 4'd1 == rank_eff);

        res_data.kind = KIND_MULTI;
        res_data.flat = '0;
        res_data.dim  = 3'(eo_reg);
        res_data.comp = comp_reg[eo_reg[DW-1:0]];
        res_data.row  = row_reg[eo_reg[DW-1:0]];
        res_data.last = olast;
        res_data.err  = ERR_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_LOAD_DIM:
                        begin
                            if (cmd.ok)
                            begin
                                kinds_next[cmd.dsel[DW-1:0]] = cmd.jagged;
                                sizes_next[cmd.dsel[DW-1:0]] = cmd.size;
                            end
                        end
                        OP_LOAD_OFF:
                        begin
                            mem_we = cmd.ok;
                        end
                        OP_TO_FLAT:
                        begin
                            d          = seen_reg[DW-1:0];
                            use_next   = (seen_reg < rank_eff);
                            ccomp_next = cmd.value;
                            clast_next = cmd.last;
                            if (seen_reg < rank_eff)
                            begin
                                if (kinds_reg[d])
                                begin
                                    if (acc_reg >= 32'(OFFSET_DEPTH))
                                    begin
                                        ovf_seen_next = 1'b1;
                                    end
                                    rd_en = 1'b1;
                                    rd_d  = d;
                                    rd_i  = {1'b0, acc_reg};
                                end
                                else
                                begin
                                    prod_next = 48'(acc_reg) * 48'(sizes_reg[d]);
                                end
                            end
                            state_next = S_FLAT2;
                        end
                        default:
                        begin
                            flat_next  = cmd.value;
                            count_next = 32'd1;
                            cd_next    = '0;
                            movf_next  = 1'b0;
                            state_next = (rank_eff == 4'd0) ? S_CHK : S_CNT;
                        end
                    endcase
                end
            end

            S_FLAT2:
            begin
                d = seen_reg[DW-1:0];
                if (use_reg)
                begin
                    v = kinds_reg[d] ? (49'(tab) + 49'(ccomp_reg))
                                     : (49'(prod_reg) + 49'(ccomp_reg));
                    if (v > 49'(LIM))
                    begin
                        ovf_n = 1'b1;
                    end
                    acc_n = v[31:0] & LIM;
                end
                seen_n = (seen_reg < 4'd15) ? seen_reg + 4'd1 : seen_reg;
                if (clast_reg)
                begin
                    err = ovf_n ? ERR_OVERFLOW : ((seen_n != rank_eff) ? ERR_COUNT : ERR_OK);
                    pend_next.kind = KIND_FLAT;
                    pend_next.flat = (err != ERR_OK) ? 32'd0 : acc_n;
                    pend_next.dim  = '0;
                    pend_next.comp = '0;
                    pend_next.row  = '0;
                    pend_next.last = 1'b1;
                    pend_next.err  = err;
                    acc_next       = '0;
                    seen_next      = '0;
                    ovf_seen_next  = 1'b0;
                    state_next     = S_PUSH;
                end
                else
                begin
                    acc_next      = acc_n;
                    seen_next     = seen_n;
                    ovf_seen_next = ovf_n;
                    state_next    = S_IDLE;
                end
            end

            S_CNT:
            begin
                d = cd_reg[DW-1:0];
                before_next[d] = count_reg;
                if (kinds_reg[d])
                begin
                    if (count_reg >= 32'(OFFSET_DEPTH))
                    begin
                        movf_next  = 1'b1;
                        count_next = '0;
                        adv        = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_d       = d;
                        rd_i       = {1'b0, count_reg};
                        state_next = S_CNT2;
                    end
                end
                else
                begin
                    prod_next  = 48'(count_reg) * 48'(sizes_reg[d]);
                    state_next = S_CNT2;
                end
            end

            S_CNT2:
            begin
                d = cd_reg[DW-1:0];
                v = kinds_reg[d] ? 49'(tab) : 49'(prod_reg);
                if (v > 49'(LIM))
                begin
                    movf_next = 1'b1;
                end
                count_next = v[31:0] & LIM;
                adv        = 1'b1;
            end

            S_CHK:
            begin
                pend_next.kind = KIND_MULTI;
                pend_next.flat = '0;
                pend_next.dim  = '0;
                pend_next.comp = '0;
                pend_next.row  = '0;
                pend_next.last = 1'b1;
                if (movf_reg)
                begin
                    pend_next.err = ERR_OVERFLOW;
                    state_next    = S_PUSH;
                end
                else if ((flat_reg >= count_reg) || ((flat_reg & ~LIM) != 32'd0))
                begin
                    pend_next.err = ERR_RANGE;
                    state_next    = S_PUSH;
                end
                else if (rank_eff == 4'd0)
                begin
                    pend_next.err = ERR_OK;
                    state_next    = S_PUSH;
                end
                else
                begin
                    pend_next.err = ERR_OK;
                    dd_next       = DW'(rank_eff - 4'd1);
                    res_next      = flat_reg;
                    state_next    = S_SPLIT;
                end
            end

            S_SPLIT:
            begin
                if (kinds_reg[d])
                begin
                    lo_next    = '0;
                    hi_next    = 33'(before_reg[d]) + 33'd1;
                    state_next = S_BS;
                end
                else if (sizes_reg[d] == 16'd0)
                begin
                    comp_next[d] = res_reg;
                    row_next[d]  = res_reg;
                    res_next     = '0;
                    nextd        = 1'b1;
                end
                else
                begin
                    q_next     = res_reg;
                    rem_next   = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end

            S_BS:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_i       = mid_c;
                    mid_next   = mid_c;
                    state_next = S_BSR;
                end
                else if (lo_reg == 33'd0)
                begin
                    comp_next[d] = res_reg;
                    row_next[d]  = res_reg;
                    res_next     = '0;
                    nextd        = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_i       = lo_reg - 33'd1;
                    state_next = S_BSE;
                end
            end

            S_BSR:
            begin
                if (tab <= res_reg)
                begin
                    lo_next = mid_reg + 33'd1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_BS;
            end

            S_BSE:
            begin
                comp_next[d] = res_reg - tab;
                row_next[d]  = res_reg;
                res_next     = 32'(lo_reg - 33'd1);
                nextd        = 1'b1;
            end

            S_DIV:
            begin
                ge        = (t >= {1'b0, sizes_reg[d]});
                rem_n     = ge ? 16'(t - {1'b0, sizes_reg[d]}) : t[15:0];
                q_n       = {q_reg[30:0], ge};
                rem_next  = rem_n;
                q_next    = q_n;
                dcnt_next = dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd31)
                begin
                    comp_next[d] = 32'(rem_n);
                    row_next[d]  = 32'(rem_n);
                    res_next     = q_n;
                    nextd        = 1'b1;
                end
            end

            S_OUT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (olast)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        eo_next = eo_reg + 4'd1;
                    end
                end
            end

            S_PUSH:
            begin
                res_data = pend_reg;
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (cd_reg + 4'd1 == rank_eff)
            begin
                state_next = S_CHK;
            end
            else
            begin
                cd_next    = cd_reg + 4'd1;
                state_next = S_CNT;
            end
        end

        if (nextd)
        begin
            if (dd_reg == '0)
            begin
                eo_next    = '0;
                state_next = S_OUT;
            end
            else
            begin
                dd_next    = dd_reg - 1'b1;
                state_next = S_SPLIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rank_reg     <= '0;
            acc_reg      <= '0;
            seen_reg     <= '0;
            ovf_seen_reg <= 1'b0;
            for (int i = 0; i < MAX_RANK; i++)
            begin
                kinds_reg[i] <= 1'b0;
                sizes_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            seen_reg     <= seen_next;
            ovf_seen_reg <= ovf_seen_next;
            kinds_reg    <= kinds_next;
            sizes_reg    <= sizes_next;
            if (cfg_write)
            begin
                rank_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        use_reg    <= use_next;
        ccomp_reg  <= ccomp_next;
        clast_reg  <= clast_next;
        prod_reg   <= prod_next;
        count_reg  <= count_next;
        cd_reg     <= cd_next;
        movf_reg   <= movf_next;
        flat_reg   <= flat_next;
        before_reg <= before_next;
        comp_reg   <= comp_next;
        row_reg    <= row_next;
        res_reg    <= res_next;
        dd_reg     <= dd_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        eo_reg     <= eo_next;
        pend_reg   <= pend_next;
    end

    // offset tables: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_zero_reg <= (rd_i >= 33'(OFFSET_DEPTH));
        end
    end

endmodule

FILE: rtl/core/ragged_index_converter.sv
// Ragged index converter: row-major index conversion for mixed uniform and
// jagged shapes. Depends on ric_pkg, ric_front, ric_back and ric_fifo.
//
// Usage:
//   Requests enter on push/full with one field port each. Dimension and
//   offset loads give no result. To-flat components give one flat result
//   on the request marked last_component. A to-multi request gives one
//   result per dimension in order 0..rank-1, or a single result at rank 0 or on error.
//   The user must write rank_in_use through cfg_write/cfg_data only while
//   idle; the block does not enforce this. Results leave on empty/pop; the
//   oldest waits on the ports while empty is low. A four-entry request
//   queue lets loads stream in while the sequencer works.
// Sequencing: the sequencer takes a new request only after the last one is
//   done. A to-multi request first builds the level totals, dimension by
//   dimension, then splits the flat index from the last dimension back by a
//   uniform divide or an offset table search, then delivers the results.
//   Offset table reads go through one memory port.
// Reset clears the shape to uniform, zero extent, rank 0 and the to-flat
// accumulator; offset table contents are unknown until written.
// A stalled receiver fills the two-entry result queue, then the sequencer
// and, behind it, the request queue hold until pop resumes.
module ragged_index_converter #(
    parameter int MAX_RANK     = ric_pkg::DEF_MAX_RANK,
    parameter int OFFSET_DEPTH = ric_pkg::DEF_OFFSET_DEPTH,
    parameter int INDEX_BITS   = ric_pkg::DEF_INDEX_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [2:0]  dim_select,
    input  logic        dim_jagged,
    input  logic [15:0] dim_size,
    input  logic [11:0] table_index,
    input  logic [31:0] prefix_value,
    input  logic [31:0] index_component,
    input  logic        last_component,
    input  logic [31:0] flat_in,
    input  logic        cfg_write,
    input  logic [3:0]  cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [31:0] flat_out,
    output logic [2:0]  dimension,
    output logic [31:0] component_out,
    output logic [31:0] row_in_dimension,
    output logic        last_result,
    output logic [1:0]  error_code
);
    import ric_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;
    res_t res_in;
    res_t res_out;
    logic res_push;
    logic res_full;

    ric_front #(
        .MAX_RANK     (MAX_RANK),
        .OFFSET_DEPTH (OFFSET_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .dim_select      (dim_select),
        .dim_jagged      (dim_jagged),
        .dim_size        (dim_size),
        .table_index     (table_index),
        .prefix_value    (prefix_value),
        .index_component (index_component),
        .last_component  (last_component),
        .flat_in         (flat_in),
        .cmd             (cmd),
        .cmd_valid       (cmd_valid),
        .cmd_pop         (cmd_pop)
    );

    ric_back #(
        .MAX_RANK     (MAX_RANK),
        .OFFSET_DEPTH (OFFSET_DEPTH),
        .INDEX_BITS   (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res_data  (res_in),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    ric_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res_in),
        .rd    (pop),
        .rdata (res_out),
        .full  (res_full),
        .empty (empty)
    );

    assign result_kind      = res_out.kind;
    assign flat_out         = res_out.flat;
    assign dimension        = res_out.dim;
    assign component_out    = res_out.comp;
    assign row_in_dimension = res_out.row;
    assign last_result      = res_out.last;
    assign error_code       = res_out.err;

endmodule

FILE: rtl/core/ric_chk.sv
// Port-level checker for the ragged index converter, bound to the top level.
// Depends on ric_pkg and ragged_index_converter_macros.svh.
`include "ragged_index_converter_macros.svh"

module ric_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        result_kind,
    input logic [31:0] flat_out,
    input logic [2:0]  dimension,
    input logic [31:0] component_out,
    input logic [31:0] row_in_dimension,
    input logic        last_result,
    input logic [1:0]  error_code
);
    import ric_pkg::*;

    `RIC_ASSERT_IMPLIES(a_err_blank, !empty && error_code != ERR_OK, last_result && flat_out == 32'd0 && component_out == 32'd0 && row_in_dimension == 32'd0, "error result carries values")
    `RIC_ASSERT_IMPLIES(a_flat_shape, !empty && result_kind == KIND_FLAT, last_result && dimension == 3'd0 && component_out == 32'd0 && row_in_dimension == 32'd0 && error_code != ERR_RANGE, "malformed flat result")
    `RIC_ASSERT_IMPLIES(a_multi_shape, !empty && result_kind == KIND_MULTI, flat_out == 32'd0 && error_code != ERR_COUNT, "malformed per-dimension result")
    `RIC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(dimension) && $stable(component_out), "waiting result lost or changed")

endmodule

bind ragged_index_converter ric_chk u_chk (.*);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for ragged_index_converter: directed shape tests, then
// random requests under three idling patterns, checked against an internal predictor.
// Depends on ric_pkg and the ragged_index_converter RTL.
module testbench;
    import ric_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  action = OP_LOAD_DIM;
    logic [2:0]  dim_select = '0;
    logic        dim_jagged = 1'b0;
    logic [15:0] dim_size = '0;
    logic [11:0] table_index = '0;
    logic [31:0] prefix_value = '0;
    logic [31:0] index_component = '0;
    logic        last_component = 1'b0;
    logic [31:0] flat_in = '0;
    logic        cfg_write = 1'b0;
    logic [3:0]  cfg_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        result_kind;
    logic [31:0] flat_out;
    logic [2:0]  dimension;
    logic [31:0] component_out;
    logic [31:0] row_in_dimension;
    logic        last_result;
    logic [1:0]  error_code;

    ragged_index_converter u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .dim_select(dim_select), .dim_jagged(dim_jagged), .dim_size(dim_size),
        .table_index(table_index), .prefix_value(prefix_value),
        .index_component(index_component), .last_component(last_component),
        .flat_in(flat_in), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .empty(empty), .pop(pop), .result_kind(result_kind), .flat_out(flat_out),
        .dimension(dimension), .component_out(component_out),
        .row_in_dimension(row_in_dimension), .last_result(last_result),
        .error_code(error_code)
    );

    localparam longint unsigned LIM = 64'hFFFF_FFFF;
    localparam int DEPTH = DEF_OFFSET_DEPTH;

    // shape model
    bit              dim_is_jagged [8];
    bit [15:0]       dim_extent [8];
    bit [31:0]       offset_mem [8][DEPTH];
    bit              offset_written [8][DEPTH];
    bit [3:0]        rank_reg;
    longint unsigned flat_acc;
    int              comps_seen;
    bit              flat_ovf;
    int              unwritten_hit;

    res_t expected_results[$];
    res_t split_results[$];
    int   send_idle, recv_idle;
    int   errors, requests_sent, results_checked;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report(string what, longint unsigned got, longint unsigned exp);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, exp);
        errors++;
    endtask

    always @(negedge clk)
        pop = ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
                report("unexpected result, kind", result_kind, 0);
            else
            begin
                e = expected_results.pop_front();
                results_checked++;
                if (result_kind !== e.kind) report("result_kind", result_kind, e.kind);
                if (flat_out !== e.flat) report("flat_out", flat_out, e.flat);
                if (dimension !== e.dim) report("dimension", dimension, e.dim);
                if (component_out !== e.comp) report("component_out", component_out, e.comp);
                if (row_in_dimension !== e.row) report("row_in_dimension", row_in_dimension, e.row);
                if (last_result !== e.last) report("last_result", last_result, e.last);
                if (error_code !== e.err) report("error_code", error_code, e.err);
            end
        end
    end

    function automatic res_t make_result(bit kind, longint unsigned flat, int dim,
                                         longint unsigned comp, longint unsigned row,
                                         bit last, logic [1:0] err);
        res_t r;
        r.kind = kind;
        r.flat = flat[31:0];
        r.dim  = dim[2:0];
        r.comp = comp[31:0];
        r.row  = row[31:0];
        r.last = last;
        r.err  = err;
        return r;
    endfunction

    function automatic int live_rank();
        return (rank_reg > 8) ? 8 : int'(rank_reg);
    endfunction

    function automatic longint unsigned table_read(int d, longint unsigned i);
        if (i >= DEPTH)
            return 0;
        if (!offset_written[d][i] && unwritten_hit < 0)
            unwritten_hit = d * DEPTH + int'(i);
        return offset_mem[d][i];
    endfunction

    // level totals, then the split from the last dimension back
    function automatic void split_flat(longint unsigned flat);
        int r;
        longint unsigned parents [8];
        longint unsigned comp [8];
        longint unsigned row [8];
        longint unsigned cnt, resid, lo, hi, mid;
        bit ovf;
        r = live_rank();
        cnt = 1;
        ovf = 0;
        split_results.delete();
        for (int d = 0; d < r; d++)
        begin
            parents[d] = cnt;
            if (dim_is_jagged[d])
            begin
                if (cnt >= DEPTH)
                begin
                    ovf = 1;
                    cnt = 0;
                end
                else
                    cnt = table_read(d, cnt);
            end
            else
                cnt = cnt * dim_extent[d];
            if (cnt > LIM)
            begin
                ovf = 1;
                cnt &= LIM;
            end
        end
        if (ovf)
            split_results.insert(split_results.size(),
                                 make_result(KIND_MULTI, 0, 0, 0, 0, 1, ERR_OVERFLOW));
        else if (flat >= cnt)
            split_results.insert(split_results.size(),
                                 make_result(KIND_MULTI, 0, 0, 0, 0, 1, ERR_RANGE));
        else if (r == 0)
            split_results.insert(split_results.size(),
                                 make_result(KIND_MULTI, 0, 0, 0, 0, 1, ERR_OK));
        else
        begin
            resid = flat;
            for (int d = r - 1; d >= 0; d--)
            begin
                if (dim_is_jagged[d])
                begin
                    lo = 0;
                    hi = parents[d] + 1;
                    while (lo < hi)
                    begin
                        mid = lo + ((hi - lo) >> 1);
                        if (table_read(d, mid) <= resid) lo = mid + 1;
                        else hi = mid;
                    end
                    row[d] = resid;
                    if (lo == 0)
                    begin
                        comp[d] = resid;
                        resid = 0;
                    end
                    else
                    begin
                        comp[d] = resid - table_read(d, lo - 1);
                        resid = lo - 1;
                    end
                end
                else
                begin
                    if (dim_extent[d] == 0)
                    begin
                        comp[d] = resid;
                        resid = 0;
                    end
                    else
                    begin
                        comp[d] = resid % dim_extent[d];
                        resid = resid / dim_extent[d];
                    end
                    row[d] = comp[d];
                end
            end
            for (int d = 0; d < r; d++)
                split_results.insert(split_results.size(),
                                     make_result(KIND_MULTI, 0, d, comp[d], row[d],
                                                 d == r - 1, ERR_OK));
        end
    endfunction

    function automatic void fold_component(longint unsigned c, bit last);
        int r;
        longint unsigned v;
        logic [1:0] err;
        r = live_rank();
        if (comps_seen < r)
        begin
            if (dim_is_jagged[comps_seen])
            begin
                if (flat_acc >= DEPTH)
                begin
                    flat_ovf = 1;
                    v = c;
                end
                else
                    v = table_read(comps_seen, flat_acc) + c;
            end
            else
                v = flat_acc * dim_extent[comps_seen] + c;
            if (v > LIM) flat_ovf = 1;
            flat_acc = v & LIM;
        end
        if (comps_seen < 15) comps_seen++;
        if (last)
        begin
            err = flat_ovf ? ERR_OVERFLOW : ((comps_seen != r) ? ERR_COUNT : ERR_OK);
            expected_results.insert(expected_results.size(),
                                    make_result(KIND_FLAT, (err != ERR_OK) ? 0 : flat_acc,
                                                0, 0, 0, 1, err));
            flat_acc = 0;
            comps_seen = 0;
            flat_ovf = 0;
        end
    endfunction

    // drives one request from the current field values; starts and ends at a falling edge
    task automatic send_request();
        while ($urandom_range(0, 99) < send_idle)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        do
            @(posedge clk);
        while (full);
        requests_sent++;
        case (action)
            OP_LOAD_DIM:
            begin
                dim_is_jagged[dim_select] = dim_jagged;
                dim_extent[dim_select] = dim_size;
            end
            OP_LOAD_OFF:
            begin
                offset_mem[dim_select][table_index] = prefix_value;
                offset_written[dim_select][table_index] = 1;
            end
            OP_TO_FLAT:
                fold_component(index_component, last_component);
            default:
            begin
                split_flat(flat_in);
                foreach (split_results[i])
                    expected_results.insert(expected_results.size(), split_results[i]);
            end
        endcase
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic scramble_fields();
        dim_select = 3'($urandom);
        dim_jagged = 1'($urandom);
        dim_size = 16'($urandom);
        table_index = 12'($urandom);
        prefix_value = $urandom;
        index_component = $urandom;
        last_component = 1'($urandom);
        flat_in = $urandom;
    endtask

    task automatic load_dim(int d, bit jag, bit [15:0] sz);
        scramble_fields();
        action = OP_LOAD_DIM;
        dim_select = 3'(d);
        dim_jagged = jag;
        dim_size = sz;
        send_request();
    endtask

    task automatic load_offset(int d, int ti, bit [31:0] v);
        scramble_fields();
        action = OP_LOAD_OFF;
        dim_select = 3'(d);
        table_index = 12'(ti);
        prefix_value = v;
        send_request();
    endtask

    task automatic flat_component(bit [31:0] c, bit last);
        int r;
        r = live_rank();
        // never let the block read an offset entry that was never written
        if (comps_seen < r && dim_is_jagged[comps_seen] && flat_acc < DEPTH
            && !offset_written[comps_seen][flat_acc])
            load_offset(comps_seen, int'(flat_acc), $urandom_range(0, 20));
        scramble_fields();
        action = OP_TO_FLAT;
        index_component = c;
        last_component = last;
        send_request();
    endtask

    task automatic multi_query(bit [31:0] f);
        forever
        begin
            unwritten_hit = -1;
            split_flat(f);
            if (unwritten_hit < 0) break;
            load_offset(unwritten_hit / DEPTH, unwritten_hit % DEPTH, $urandom_range(0, 20));
        end
        scramble_fields();
        action = OP_TO_MULTI;
        flat_in = f;
        send_request();
    endtask

    function automatic longint unsigned level_total(output bit ovf);
        longint unsigned cnt;
        cnt = 1;
        ovf = 0;
        for (int d = 0; d < live_rank(); d++)
        begin
            if (dim_is_jagged[d])
                cnt = (cnt >= DEPTH) ? 0 : offset_mem[d][cnt];
            else
                cnt = cnt * dim_extent[d];
            if (cnt > LIM) ovf = 1;
            cnt &= LIM;
        end
        return cnt;
    endfunction

    task automatic drain();
        while (expected_results.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_rank(bit [3:0] v);
        drain();
        cfg_write = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 1'b0;
        rank_reg = v;
    endtask

    // well-formed shape with small levels; jagged tables written in full
    task automatic build_shape(int n, int jag_pct);
        longint unsigned cells, off;
        cells = 1;
        for (int d = 0; d < n; d++)
        begin
            if ($urandom_range(0, 99) < jag_pct && cells < 40)
            begin
                load_dim(d, 1, 16'($urandom));
                off = 0;
                for (int p = 0; p <= cells; p++)
                begin
                    load_offset(d, p, 32'(off));
                    off += $urandom_range(0, 3);
                end
                cells = off;
            end
            else
            begin
                load_dim(d, 0, 16'((cells > 40) ? 1 : $urandom_range(1, 4)));
                cells = cells * dim_extent[d];
            end
        end
    endtask

    task automatic flat_query_in_range();
        int r;
        r = live_rank();
        for (int d = 0; d < r; d++)
            flat_component(dim_is_jagged[d] ? $urandom_range(0, 3)
                           : $urandom_range(0, (dim_extent[d] == 0) ? 0 : dim_extent[d] - 1),
                           d == r - 1);
        if (r == 0) flat_component(0, 1);
    endtask

    task automatic test_reset_state();
        multi_query(0);
        multi_query(5);
        flat_component(32'hFFFF_FFFF, 1);
    endtask

    task automatic test_uniform();
        set_rank(3);
        load_dim(0, 0, 3);
        load_dim(1, 0, 4);
        load_dim(2, 0, 5);
        multi_query(0);
        multi_query(59);
        multi_query(60);
        multi_query(32'hFFFF_FFFF);
        flat_component(2, 0);
        flat_component(3, 0);
        flat_component(4, 1);
        flat_component(32'hFFFF_FFFF, 0);
        flat_component(0, 0);
        flat_component(0, 1);
        flat_component(1, 0);
        flat_component(1, 1);
        load_dim(1, 0, 0);
        multi_query(0);
        load_dim(1, 0, 16'hFFFF);
        load_dim(2, 0, 16'hFFFF);
        multi_query(7);
    endtask

    task automatic test_jagged();
        set_rank(3);
        build_shape(3, 70);
        multi_query(0);
        multi_query($urandom_range(0, 30));
        flat_query_in_range();
        load_offset(1, 1, 32'hFFFF_FFF0);
        multi_query(3);
        flat_query_in_range();
        load_dim(0, 0, 5000);
        load_dim(1, 1, 0);
        multi_query(1);
        flat_component(4999, 0);
        flat_component(0, 1);
    endtask

    task automatic test_rank_saturation();
        build_shape(8, 30);
        set_rank(15);
        multi_query(0);
        for (int i = 0; i < 9; i++) flat_component(0, i == 8);
        set_rank(9);
        flat_query_in_range();
        set_rank(8);
        flat_query_in_range();
        multi_query(1);
    endtask

    task automatic test_random(int s_idle, int r_idle, int count);
        bit ovf;
        longint unsigned total;
        send_idle = s_idle;
        recv_idle = r_idle;
        set_rank(4'($urandom_range(1, 8)));
        build_shape(8, 50);
        repeat (count)
        begin
            total = level_total(ovf);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    multi_query((total == 0) ? 0 : $urandom_range(0, int'(total - 1)));
                8:
                    multi_query($urandom);
                9, 10, 11, 12, 13, 14:
                    flat_query_in_range();
                15:
                    for (int i = $urandom_range(0, 9); i >= 0; i--)
                        flat_component($urandom, i == 0);
                16:
                    load_dim($urandom_range(0, 7), 0, 16'($urandom_range(0, 5)));
                17:
                    load_dim($urandom_range(0, 7), 0, 16'($urandom));
                default:
                    load_offset($urandom_range(0, 7), $urandom_range(0, 40), $urandom_range(0, 60));
            endcase
        end
    endtask

    initial
    begin
        send_idle = 0;
        recv_idle = 0;
        rank_reg = 0;
        flat_acc = 0;
        comps_seen = 0;
        flat_ovf = 0;
        errors = 0;
        requests_sent = 0;
        results_checked = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_uniform();
        test_jagged();
        test_rank_saturation();
        test_random(17, 84, 15);
        test_random(84, 17, 15);
        test_random(0, 0, 15);

        drain();
        $display("Sent %0d requests across uniform, jagged and saturated-rank shapes;",
                 requests_sent);
        $display("checked %0d results, %0d mismatches.", results_checked, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
